@@ hdl/ihpl_pkg.sv @@
// ----------------------------------------------------------------------------
// ihpl_pkg: shared types and constants of the hex page loader
// Request and result structs, operation and status codes, parser phases
// and the hex digit decoder.
// ----------------------------------------------------------------------------
package ihpl_pkg;

  localparam int unsigned PageBytes   = 256;
  localparam int unsigned LineBytesDef = 256;

  localparam logic [7:0]  EscChar   = 8'h1b;
  localparam logic [7:0]  ColonChar = 8'h3a;
  localparam logic [15:0] PageMask  = 16'hff00;

  typedef enum logic [1:0] {
    OP_PARSE = 2'd0,
    OP_READ  = 2'd1,
    OP_ACK   = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_CSERR = 2'd1,
    ST_PAGE  = 2'd2,
    ST_EOF   = 2'd3
  } status_e;

  // record parser phases
  typedef enum logic [7:0] {
    PH_WAIT   = 8'b0000_0001,
    PH_COUNT  = 8'b0000_0010,
    PH_ADDR   = 8'b0000_0100,
    PH_TYPE   = 8'b0000_1000,
    PH_DATA   = 8'b0001_0000,
    PH_SUM    = 8'b0010_0000,
    PH_EOFSUM = 8'b0100_0000,
    PH_COPY   = 8'b1000_0000
  } phase_e;

  // back-end sequencer states
  typedef enum logic [2:0] {
    SQ_IDLE = 3'b001,
    SQ_COPY = 3'b010,
    SQ_WORD = 3'b100
  } seq_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_in;
    logic [6:0] word_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] page_base;
    logic [15:0] record_address;
    logic [15:0] read_word;
  } out_item_t;

  // hex digit value, 16 when the character is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    return v;
  endfunction

endpackage

@@ hdl/ihpl_ram.sv @@
// ----------------------------------------------------------------------------
// ihpl_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ihpl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ihpl_front.sv @@
// ----------------------------------------------------------------------------
// ihpl_front: request intake
// Two-entry queue that takes requests while the back end is busy.
// ----------------------------------------------------------------------------
module ihpl_front
  import ihpl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_i,
  output logic     req_valid_o,
  input  logic     req_pop_i,
  output in_item_t req_o
);

  in_item_t   slot_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign req_valid_o = (cnt_q != 2'd0);
  assign pop         = req_pop_i && req_valid_o;
  assign req_o       = slot_q[rptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wptr_d = push ? !wptr_q : wptr_q;
    rptr_d = pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wptr_q] <= in_i;
  end

endmodule

@@ hdl/ihpl_back.sv @@
// ----------------------------------------------------------------------------
// ihpl_back: record parser and page copy engine
// Parses one request at a time, copies checked lines into the page
// buffer one byte a cycle and holds the result until it is taken.
// ----------------------------------------------------------------------------
module ihpl_back
  import ihpl_pkg::*;
#(
  parameter int unsigned LINE_BYTES = LineBytesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_pop_o,
  input  in_item_t  req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  localparam int unsigned LineAw = $clog2(LINE_BYTES);
  localparam logic [8:0]  LineLim = 9'(LINE_BYTES);

  seq_e        seq_q, seq_d;
  phase_e      phase_q, phase_d;
  logic [15:0] buf_q, buf_d;
  logic [2:0]  left_q, left_d;
  logic        stop_q, stop_d;
  logic [7:0]  count_q, count_d;
  logic [15:0] laddr_q, laddr_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  fill_q, fill_d;
  logic [7:0]  coff_q, coff_d;
  logic [15:0] paddr_q, paddr_d;
  logic [7:0]  wpos_q, wpos_d;
  logic        holds_q, holds_d;
  logic        oval_q, oval_d;
  out_item_t   out_q, out_d;
  logic [PageBytes-1:0] pv_q, pv_d;
  logic        rv_lo_q, rv_hi_q;

  // memory ports
  logic [7:0]  lrd_idx;
  logic        lwe;
  logic [7:0]  lwdata;
  logic [7:0]  lrdata;
  logic        pwe_even, pwe_odd;
  logic [6:0]  prd_addr;
  logic [7:0]  pbyte;
  logic [7:0]  prd_even, prd_odd;

  ihpl_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (lwe),
    .waddr_i (fill_q[LineAw-1:0]),
    .wdata_i (lwdata),
    .raddr_i (lrd_idx[LineAw-1:0]),
    .rdata_o (lrdata)
  );

  ihpl_ram #(.WIDTH(8), .DEPTH(PageBytes / 2)) u_page_even (
    .clk_i   (clk_i),
    .we_i    (pwe_even),
    .waddr_i (wpos_q[7:1]),
    .wdata_i (pbyte),
    .raddr_i (prd_addr),
    .rdata_o (prd_even)
  );

  ihpl_ram #(.WIDTH(8), .DEPTH(PageBytes / 2)) u_page_odd (
    .clk_i   (clk_i),
    .we_i    (pwe_odd),
    .waddr_i (wpos_q[7:1]),
    .wdata_i (pbyte),
    .raddr_i (prd_addr),
    .rdata_o (prd_odd)
  );

  assign out_valid_o = oval_q;
  assign out_o       = out_q;

  // sequencer, parser and copy engine
  always_comb begin
    logic [4:0]  h;
    logic [15:0] v;
    logic [7:0]  nxt;
    logic [7:0]  nfill;
    logic        fire;
    logic [1:0]  st;

    seq_d    = seq_q;
    phase_d  = phase_q;
    buf_d    = buf_q;
    left_d   = left_q;
    stop_d   = stop_q;
    count_d  = count_q;
    laddr_d  = laddr_q;
    sum_d    = sum_q;
    fill_d   = fill_q;
    coff_d   = coff_q;
    paddr_d  = paddr_q;
    wpos_d   = wpos_q;
    holds_d  = holds_q;
    pv_d     = pv_q;
    oval_d   = oval_q && out_stall_i;
    out_d    = out_q;
    req_pop_o = 1'b0;
    lrd_idx  = coff_q;
    lwe      = 1'b0;
    lwdata   = '0;
    pwe_even = 1'b0;
    pwe_odd  = 1'b0;
    pbyte    = ({1'b0, coff_q} < LineLim) ? lrdata : 8'hff;
    prd_addr = req_i.word_index;
    h        = hex_value(req_i.char_in);
    v        = buf_q;
    nxt      = coff_q + 8'd1;
    nfill    = fill_q + 8'd1;
    fire     = 1'b0;
    st       = ST_BUSY;

    case (seq_q)
      SQ_IDLE: begin
        if (req_valid_i && !oval_q) begin
          req_pop_o = 1'b1;
          fire      = 1'b1;
          case (req_i.op)
            OP_PARSE: begin
              if (req_i.char_in == EscChar) begin
                phase_d = PH_WAIT;
              end else if (phase_q == PH_WAIT) begin
                if (req_i.char_in == ColonChar) begin
                  laddr_d = '0;
                  count_d = '0;
                  sum_d   = '0;
                  fill_d  = '0;
                  coff_d  = '0;
                  phase_d = PH_COUNT;
                  buf_d   = '0;
                  left_d  = 3'd2;
                  stop_d  = 1'b0;
                end
              end else if (phase_q == PH_COPY) begin
                if (holds_q) begin
                  st = ST_PAGE;
                end else begin
                  paddr_d = paddr_q + 16'(PageBytes);
                  wpos_d  = '0;
                  lrd_idx = coff_q;
                  fire    = 1'b0;
                  seq_d   = SQ_COPY;
                end
              end else begin
                // next digit of the current field
                if (!stop_q && h < 5'd16) begin
                  buf_d = {buf_q[11:0], h[3:0]};
                end else begin
                  stop_d = 1'b1;
                end
                v = buf_d;
                if (left_q > 3'd1) begin
                  left_d = left_q - 3'd1;
                end else begin
                  left_d = '0;
                  buf_d  = '0;
                  stop_d = 1'b0;
                  left_d = 3'd2;
                  case (phase_q)
                    PH_COUNT: begin
                      count_d = v[7:0];
                      sum_d   = v[7:0];
                      phase_d = PH_ADDR;
                      left_d  = 3'd4;
                    end
                    PH_ADDR: begin
                      laddr_d = v;
                      sum_d   = sum_q + v[7:0] + v[15:8];
                      if (holds_q && ((v & PageMask) != paddr_q)) st = ST_PAGE;
                      phase_d = PH_TYPE;
                    end
                    PH_TYPE: begin
                      sum_d = sum_q + v[7:0];
                      if (v[7:0] == 8'd0) begin
                        fill_d  = '0;
                        phase_d = (count_q != 8'd0) ? PH_DATA : PH_SUM;
                      end else if (v[7:0] == 8'd1) begin
                        phase_d = PH_EOFSUM;
                      end else begin
                        phase_d = PH_WAIT;
                        left_d  = '0;
                      end
                    end
                    PH_DATA: begin
                      lwe     = ({1'b0, fill_q} < LineLim);
                      lwdata  = v[7:0];
                      sum_d   = sum_q + v[7:0];
                      fill_d  = nfill;
                      phase_d = (nfill == count_q) ? PH_SUM : PH_DATA;
                    end
                    PH_SUM: begin
                      sum_d  = sum_q + v[7:0];
                      left_d = '0;
                      if (sum_d != 8'd0) begin
                        phase_d = PH_WAIT;
                        st      = ST_CSERR;
                      end else begin
                        paddr_d = laddr_q & PageMask;
                        wpos_d  = laddr_q[7:0];
                        coff_d  = '0;
                        phase_d = PH_WAIT;
                        if (count_q != 8'd0) begin
                          lrd_idx = '0;
                          fire    = 1'b0;
                          seq_d   = SQ_COPY;
                        end
                      end
                    end
                    PH_EOFSUM: begin
                      sum_d   = sum_q + v[7:0];
                      st      = (sum_d != 8'd0) ? ST_CSERR : ST_EOF;
                      phase_d = PH_WAIT;
                      left_d  = '0;
                    end
                    default: begin
                      phase_d = PH_WAIT;
                      left_d  = '0;
                    end
                  endcase
                end
              end
            end
            OP_READ: begin
              fire  = 1'b0;
              seq_d = SQ_WORD;
            end
            OP_ACK: begin
              holds_d = 1'b0;
            end
            default: ;
          endcase
        end
      end

      // one line byte into the page each cycle
      SQ_COPY: begin
        pwe_even     = !wpos_q[0];
        pwe_odd      = wpos_q[0];
        pv_d[wpos_q] = 1'b1;
        holds_d      = 1'b1;
        wpos_d       = wpos_q + 8'd1;
        coff_d       = nxt;
        if (wpos_q == 8'hff) begin
          phase_d = (nxt < count_q) ? PH_COPY : PH_WAIT;
          st      = ST_PAGE;
          fire    = 1'b1;
          seq_d   = SQ_IDLE;
        end else if (nxt < count_q) begin
          lrd_idx = nxt;
        end else begin
          phase_d = PH_WAIT;
          fire    = 1'b1;
          seq_d   = SQ_IDLE;
        end
      end

      SQ_WORD: begin
        fire  = 1'b1;
        seq_d = SQ_IDLE;
      end

      default: seq_d = SQ_IDLE;
    endcase

    // result register
    if (fire) begin
      oval_d               = 1'b1;
      out_d.status         = st;
      out_d.page_base      = paddr_d;
      out_d.record_address = laddr_d;
      out_d.read_word      = '0;
      if (seq_q == SQ_WORD) begin
        out_d.read_word = {rv_hi_q ? prd_odd : 8'hff, rv_lo_q ? prd_even : 8'hff};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= SQ_IDLE;
      phase_q <= PH_WAIT;
      buf_q   <= '0;
      left_q  <= '0;
      stop_q  <= 1'b0;
      count_q <= '0;
      laddr_q <= '0;
      sum_q   <= '0;
      fill_q  <= '0;
      coff_q  <= '0;
      paddr_q <= '0;
      wpos_q  <= '0;
      holds_q <= 1'b0;
      oval_q  <= 1'b0;
      pv_q    <= '0;
    end else begin
      seq_q   <= seq_d;
      phase_q <= phase_d;
      buf_q   <= buf_d;
      left_q  <= left_d;
      stop_q  <= stop_d;
      count_q <= count_d;
      laddr_q <= laddr_d;
      sum_q   <= sum_d;
      fill_q  <= fill_d;
      coff_q  <= coff_d;
      paddr_q <= paddr_d;
      wpos_q  <= wpos_d;
      holds_q <= holds_d;
      oval_q  <= oval_d;
      pv_q    <= pv_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    rv_lo_q <= pv_q[{prd_addr, 1'b0}];
    rv_hi_q <= pv_q[{prd_addr, 1'b1}];
  end

endmodule

@@ hdl/intel_hex_page_loader.sv @@
// A checksum character that copies a line moves its bytes into the page
// one byte a cycle through the line RAM read port.
// Throughput: one request at a time in the back end, two more queued.
// Reset: asynchronous, active low; parser idle and page buffer reads 0xff.
// ----------------------------------------------------------------------------
// intel_hex_page_loader: Intel HEX record parser with page buffer
// Parses HEX text character by character and gathers checked data
// records into a 256-byte page that software reads back as words.
// ----------------------------------------------------------------------------
module intel_hex_page_loader
  import ihpl_pkg::*;
#(
  parameter int unsigned LINE_BYTES = LineBytesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  logic     req_valid;
  logic     req_pop;
  in_item_t req;

  ihpl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .req_valid_o (req_valid),
    .req_pop_i   (req_pop),
    .req_o       (req)
  );

  ihpl_back #(.LINE_BYTES(LINE_BYTES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_pop_o   (req_pop),
    .req_i       (req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

@@ hdl/ihpl_checker.sv @@
// ----------------------------------------------------------------------------
// ihpl_checker: port-level checks of the hex page loader
// Watches the result channel and the page base it reports.
// ----------------------------------------------------------------------------
module ihpl_checker
  import ihpl_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input out_item_t out_i
);

  // no result while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_i))
    else $error("stalled result changed");

  // page base is page aligned
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_i.page_base[7:0] == 8'd0)
    else $error("page base not aligned");

  // results with a status other than busy carry no read word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_i.status != ST_BUSY |-> out_i.read_word == 16'd0)
    else $error("read word set on a parse status");

endmodule

bind intel_hex_page_loader ihpl_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_i       (out_o)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the hex page loader
// Drives directed and random HEX text, page reads and acknowledges, predicts
// every result with a behavioural model of the parser and page buffer, and
// compares each result field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ihpl_pkg::*;

  localparam int unsigned LineMax  = LineBytesDef;
  localparam int unsigned CycleCap = 3000000;

  // parser phases of the predictor
  typedef enum int {
    P_WAIT, P_COUNT, P_ADDR, P_TYPE, P_DATA, P_SUM, P_EOFSUM, P_COPY
  } pphase_e;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_o;

  intel_hex_page_loader dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // predictor state
  pphase_e     m_phase;
  logic [15:0] m_digits;
  int          m_left;
  bit          m_stopped;
  logic [7:0]  m_count;
  logic [15:0] m_addr;
  logic [7:0]  m_type;
  logic [7:0]  m_sum;
  int          m_fill;
  int          m_copy_off;
  logic [7:0]  m_line  [LineMax];
  logic [7:0]  m_page  [PageBytes];
  logic [15:0] m_page_addr;
  logic [7:0]  m_wpos;
  bit          m_holds;

  out_item_t expected_q[$];
  in_item_t  request_q[$];
  int        n_errors;
  bit        hold_off;
  bit        quiet;
  int        cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic logic [1:0] copy_line_bytes();
    bit full;
    int i;
    full = 0;
    i = m_copy_off;
    while (i < m_count) begin
      m_page[m_wpos] = (i < LineMax) ? m_line[i] : 8'hff;
      i++;
      m_holds = 1;
      m_wpos++;
      if (m_wpos == 8'd0) begin
        full = 1;
        break;
      end
    end
    m_copy_off = i;
    m_phase = (full && i < m_count) ? P_COPY : P_WAIT;
    return full ? ST_PAGE : ST_BUSY;
  endfunction

  function automatic void open_field(input pphase_e ph, input int n);
    m_phase = ph;
    m_digits = '0;
    m_left = n;
    m_stopped = 0;
  endfunction

  function automatic logic [1:0] close_field();
    logic [15:0] v;
    logic [1:0]  st;
    v = m_digits;
    st = ST_BUSY;
    case (m_phase)
      P_COUNT: begin
        m_count = v[7:0];
        m_sum = m_count;
        open_field(P_ADDR, 4);
      end
      P_ADDR: begin
        m_addr = v;
        m_sum = m_sum + v[7:0] + v[15:8];
        if (m_holds && (v & PageMask) != m_page_addr) st = ST_PAGE;
        open_field(P_TYPE, 2);
      end
      P_TYPE: begin
        m_type = v[7:0];
        m_sum = m_sum + m_type;
        if (m_type == 8'd0) begin
          m_fill = 0;
          open_field(m_count != 0 ? P_DATA : P_SUM, 2);
        end else if (m_type == 8'd1) begin
          open_field(P_EOFSUM, 2);
        end else begin
          m_phase = P_WAIT;
        end
      end
      P_DATA: begin
        if (m_fill < LineMax) m_line[m_fill] = v[7:0];
        m_sum = m_sum + v[7:0];
        m_fill++;
        open_field(m_fill == m_count ? P_SUM : P_DATA, 2);
      end
      P_SUM: begin
        m_sum = m_sum + v[7:0];
        if (m_sum != 0) begin
          m_phase = P_WAIT;
          st = ST_CSERR;
        end else begin
          m_page_addr = m_addr & PageMask;
          m_wpos = m_addr[7:0];
          m_copy_off = 0;
          st = copy_line_bytes();
        end
      end
      P_EOFSUM: begin
        m_sum = m_sum + v[7:0];
        st = (m_sum != 0) ? ST_CSERR : ST_EOF;
        m_phase = P_WAIT;
      end
      default: m_phase = P_WAIT;
    endcase
    return st;
  endfunction

  function automatic logic [1:0] parse_char(input logic [7:0] c);
    logic [4:0] h;
    if (c == EscChar) begin
      m_phase = P_WAIT;
      return ST_BUSY;
    end
    if (m_phase == P_WAIT) begin
      if (c == ColonChar) begin
        m_addr = '0;
        m_count = '0;
        m_sum = '0;
        m_type = '0;
        m_fill = 0;
        m_copy_off = 0;
        open_field(P_COUNT, 2);
      end
      return ST_BUSY;
    end
    if (m_phase == P_COPY) begin
      if (m_holds) return ST_PAGE;
      m_page_addr = m_page_addr + 16'(PageBytes);
      m_wpos = '0;
      return copy_line_bytes();
    end
    h = 5'd16;
    if (c >= "0" && c <= "9") h = 5'(c - "0");
    else if (c >= "a" && c <= "f") h = 5'(c - "a" + 10);
    else if (c >= "A" && c <= "F") h = 5'(c - "A" + 10);
    if (!m_stopped && h < 16) m_digits = {m_digits[11:0], h[3:0]};
    else m_stopped = 1;
    if (m_left > 1) begin
      m_left--;
      return ST_BUSY;
    end
    m_left = 0;
    return close_field();
  endfunction

  // predicted result of one request
  function automatic out_item_t loader_result(input in_item_t r);
    out_item_t o;
    o = '0;
    case (op_e'(r.op))
      OP_PARSE: o.status = parse_char(r.char_in);
      OP_READ:  o.read_word = {m_page[{r.word_index, 1'b1}], m_page[{r.word_index, 1'b0}]};
      OP_ACK:   m_holds = 0;
      default: ;
    endcase
    o.page_base = m_page_addr;
    o.record_address = m_addr;
    return o;
  endfunction

  function automatic in_item_t mk(input op_e op, input logic [7:0] c, input logic [6:0] w);
    in_item_t r;
    r.op = op;
    r.char_in = c;
    r.word_index = w;
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'("0") + 8'(n);
    return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(n - 10);
  endfunction

  task automatic push_char(input logic [7:0] c);
    request_q.push_back(mk(OP_PARSE, c, '0));
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_char(hex_char(b[7:4]));
    push_char(hex_char(b[3:0]));
  endtask

  // one HEX record with random content; optionally a bad sum
  task automatic push_record(input logic [7:0] n, input logic [15:0] a,
                             input logic [7:0] t, input bit bad);
    logic [7:0] s;
    logic [7:0] d;
    s = n + a[7:0] + a[15:8] + t;
    push_char(ColonChar);
    push_byte(n);
    push_byte(a[15:8]);
    push_byte(a[7:0]);
    push_byte(t);
    for (int i = 0; i < n; i++) begin
      d = 8'($urandom);
      s += d;
      push_byte(d);
    end
    push_byte(bad ? 8'(-s + 1) : 8'(-s));
  endtask

  // directed table: request and, where it is obvious, the expected result
  typedef struct {
    in_item_t req;
    bit       known;
    out_item_t want;
  } row_t;

  // driver; valid drops after the last request of a batch is taken
  task automatic send_all();
    while (request_q.size() > 0) begin
      in_item_t r;
      r = request_q.pop_front();
      if (!quiet && $urandom_range(0, 99) < 35) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_i <= r;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      expected_q.push_back(loader_result(r));
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver stall
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else if (quiet) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 99) < 35);
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", 16'd0, 16'd0);
      end else begin
        out_item_t e;
        e = expected_q.pop_front();
        if (out_o.status != e.status) report("status", 16'(out_o.status), 16'(e.status));
        if (out_o.page_base != e.page_base) report("page_base", out_o.page_base, e.page_base);
        if (out_o.record_address != e.record_address)
          report("record_address", out_o.record_address, e.record_address);
        if (out_o.read_word != e.read_word) report("read_word", out_o.read_word, e.read_word);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    row_t  rows[$];
    row_t  rw;
    int    n_items;
    string txt;
    n_errors = 0;
    cycles = 0;
    hold_off = 0;
    quiet = 0;
    in_valid_i = 1'b0;
    in_i = '0;
    out_stall_i = 1'b0;
    m_phase = P_WAIT;
    m_digits = '0;
    m_left = 0;
    m_stopped = 0;
    m_count = '0;
    m_addr = '0;
    m_type = '0;
    m_sum = '0;
    m_fill = 0;
    m_copy_off = 0;
    foreach (m_line[i]) m_line[i] = '0;
    foreach (m_page[i]) m_page[i] = 8'hff;
    m_page_addr = '0;
    m_wpos = '0;
    m_holds = 0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reads after reset, nop, ack, escape, junk outside a record
    rw.known = 1;
    rw.want = '0;
    rw.want.read_word = 16'hffff;
    rw.req = mk(OP_READ, 8'hff, 7'd0);   rows.push_back(rw);
    rw.req = mk(OP_READ, 8'h00, 7'd127); rows.push_back(rw);
    rw.want.read_word = '0;
    rw.req = mk(OP_NOP, 8'hff, 7'h7f);   rows.push_back(rw);
    rw.req = mk(OP_ACK, 8'h00, 7'd0);    rows.push_back(rw);
    rw.req = mk(OP_PARSE, 8'h00, 7'd0);  rows.push_back(rw);
    rw.req = mk(OP_PARSE, 8'hff, 7'd0);  rows.push_back(rw);
    rw.req = mk(OP_PARSE, EscChar, 7'd0); rows.push_back(rw);
    // record ":00000001FF" ends the file
    rw.known = 0;
    txt = ":00000001F";
    for (int i = 0; i < txt.len(); i++) begin
      rw.req = mk(OP_PARSE, txt[i], 7'd0);
      rows.push_back(rw);
    end
    rw.known = 1;
    rw.want = '0;
    rw.want.status = ST_EOF;
    rw.req = mk(OP_PARSE, "F", 7'd0);
    rows.push_back(rw);
    // escape mid-record, then a non-hex digit field
    rw.known = 0;
    txt = ":1\x1b:0g0000";
    for (int i = 0; i < txt.len(); i++) begin
      rw.req = mk(OP_PARSE, txt[i], 7'd0);
      rows.push_back(rw);
    end
    foreach (rows[i]) begin
      request_q.push_back(rows[i].req);
      send_all();
      // a typed-in answer stands in for the prediction
      if (rows[i].known) expected_q[$] = rows[i].want;
    end

    // long line past the page end, unknown type, bad sum, eof with count, empty record
    push_record(8'd255, 16'h12f0, 8'd0, 0);
    for (int i = 0; i < 6; i++) push_char(8'($urandom));
    request_q.push_back(mk(OP_ACK, 8'd0, 7'd0));
    for (int i = 0; i < 3; i++) push_char(".");
    push_record(8'd4, 16'h0010, 8'd7, 0);
    push_record(8'd2, 16'h0020, 8'd0, 1);
    push_record(8'd1, 16'h0000, 8'd1, 0);
    push_record(8'd0, 16'habcd, 8'd0, 0);
    send_all();

    // receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      begin
        for (int i = 0; i < 40; i++) push_char(8'($urandom));
        send_all();
      end
    join

    // random part
    n_items = 0;
    while (n_items < 1100) begin
      int k;
      k = $urandom_range(0, 99);
      if (n_items > 400 && n_items < 700) quiet = 1;
      else quiet = 0;
      if (k < 55) begin
        push_record(8'($urandom_range(0, 24)),
                    {8'($urandom_range(0, 3)), 8'($urandom)},
                    ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 3)) : 8'd0,
                    $urandom_range(0, 9) == 0);
      end else if (k < 70) begin
        request_q.push_back(mk(OP_READ, 8'($urandom), 7'($urandom)));
      end else if (k < 82) begin
        request_q.push_back(mk(OP_ACK, 8'($urandom), 7'($urandom)));
      end else if (k < 85) begin
        request_q.push_back(mk(OP_NOP, 8'($urandom), 7'($urandom)));
      end else if (k < 88) begin
        push_char(EscChar);
      end else begin
        push_char(($urandom_range(0, 1)) ? hex_char(4'($urandom)) : 8'($urandom));
      end
      n_items += request_q.size();
      send_all();
    end
    quiet = 0;

    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (n_errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
